// File: hw/rtl/hbsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbsf_pkg
// Shared types and constants for the HDLC bit stuffing framer / deframer.
// ----------------------------------------------------------------------------
package hbsf_pkg;

	// framing constants
	localparam int          FLAG_BITS    = 8;
	localparam int          RUN_LIMIT    = 5;
	localparam int          MAX_RESULTS  = 18;
	localparam int          CNT_W        = $clog2(MAX_RESULTS + 1);
	localparam logic [7:0]  FLAG_PATTERN = 8'h7E;

	// direction register codes
	localparam logic DIR_FRAME   = 1'b0;
	localparam logic DIR_DEFRAME = 1'b1;

	// one input item
	typedef struct packed {
		logic in_bit;
		logic frame_last;
	} item_t;

	// one result item
	typedef struct packed {
		logic out_bit;
		logic has_bit;
		logic frame_end;
	} result_t;

	// what one accepted item has to emit, handed to the emitter
	typedef struct packed {
		logic             direct;  // single result given as is (deframer)
		logic             data;    // payload bit, or the direct result bit
		logic             has;     // direct result has_bit
		logic             fend;    // direct result frame_end
		logic             open;    // opening flag goes first
		logic             stuff;   // stuffed zero after the data bit
		logic             close;   // closing flag goes last
		logic [CNT_W-1:0] count;   // number of results, at least one
	} plan_t;

	// flag bit at a given position, most significant bit sent first
	function automatic logic flag_bit(input logic [2:0] pos);
		logic [2:0] sel;
		sel = 3'(FLAG_BITS - 1) - pos;
		return FLAG_PATTERN[sel];
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/hbsf_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbsf_emit
// Holds one request's plan; sends its results one per cycle while not stalled
// through a result register; takes the next plan as the last result leaves.
// ----------------------------------------------------------------------------
module hbsf_emit import hbsf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire plan_t   plan,
	output logic         take_ok,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	logic             valid_s1;
	plan_t            plan_s1;
	logic [CNT_W-1:0] idx_s1;
	logic             out_valid_q;
	result_t          result_q;

	logic             out_load;
	logic             fire;
	logic             done;
	result_t          cur;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] fpos;

	// handshake between plan stage and result register
	assign out_load = !out_valid_q || result_ready;
	assign fire     = valid_s1 && out_load;
	assign done     = fire && (idx_s1 == plan_s1.count - CNT_W'(1));
	assign take_ok  = !valid_s1 || done;

	// result at the current position of the plan
	always_comb begin
		cur  = '0;
		pos  = idx_s1;
		fpos = '0;
		if (plan_s1.direct) begin
			cur.out_bit   = plan_s1.data;
			cur.has_bit   = plan_s1.has;
			cur.frame_end = plan_s1.fend;
		end else begin
			cur.has_bit = 1'b1;
			if (plan_s1.open && idx_s1 < CNT_W'(FLAG_BITS)) begin
				cur.out_bit = flag_bit(idx_s1[2:0]);
			end else begin
				if (plan_s1.open) begin
					pos = idx_s1 - CNT_W'(FLAG_BITS);
				end
				if (pos == '0) begin
					cur.out_bit = plan_s1.data;
				end else if (plan_s1.stuff && pos == CNT_W'(1)) begin
					cur.out_bit = 1'b0;
				end else begin
					// closing flag position
					fpos          = pos - CNT_W'(1) - CNT_W'(plan_s1.stuff);
					cur.out_bit   = flag_bit(fpos[2:0]);
					cur.frame_end = (fpos[2:0] == 3'(FLAG_BITS - 1));
				end
			end
		end
	end

	// plan stage and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
				idx_s1   <= '0;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end else if (fire) begin
				idx_s1 <= idx_s1 + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= fire;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			plan_s1 <= plan;
		end
		if (fire) begin
			result_q <= cur;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

	// checks
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_s1 < plan_s1.count)
		else $error("plan position beyond result count");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> plan_s1.count != '0 && plan_s1.count <= CNT_W'(MAX_RESULTS))
		else $error("plan with bad result count");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> take_ok)
		else $error("plan loaded over a plan still sending");

endmodule
`default_nettype wire

// File: hw/rtl/hdlc_bit_stuff_framer.sv
`default_nettype none
// The first result of a request passes the plan register, then the result register, to the output.
// Throughput: one request per cycle while each gives at most one result and the
// result side is not stalled; a framing request that opens or closes a frame
// or stuffs a zero holds the input until its last result (up to 18) is sent.
// Reset: direction is framing, no frame open, counters and delay line clear.
// ----------------------------------------------------------------------------
// hdlc_bit_stuff_framer
// Bit-serial HDLC framer (flags, zero insertion) and deframer (flag removal
// through an eight-bit delay line, zero deletion), chosen by direction.
// ----------------------------------------------------------------------------
module hdlc_bit_stuff_framer import hbsf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result,
	input  wire logic    cfg_we,
	input  wire logic    cfg_wdata
);

	logic       dir_q;
	logic [2:0] ones_q;
	logic       in_frame_q;
	logic [4:0] bits_seen_q;
	logic [7:0] delay_q;

	logic       ones_nxt_en;
	logic [2:0] ones_nxt;
	logic       in_frame_nxt;
	logic [4:0] bits_seen_nxt;
	logic [7:0] delay_nxt;

	logic       accept;
	logic       take_ok;
	plan_t      plan;
	logic       plan_valid;
	logic [2:0] ones_base;
	logic [2:0] ones_inc;
	logic       popped;
	logic       have;

	assign item_ready = take_ok;
	assign accept     = item_valid && item_ready;

	// per-request state update and result plan
	always_comb begin
		ones_nxt      = ones_q;
		in_frame_nxt  = 1'b1;
		bits_seen_nxt = bits_seen_q;
		delay_nxt     = delay_q;
		plan          = '0;
		plan_valid    = 1'b0;
		ones_nxt_en   = 1'b0;
		ones_base     = '0;
		ones_inc      = '0;
		popped        = 1'b0;
		have          = 1'b0;
		if (dir_q == DIR_FRAME) begin
			// framer: flags around the frame, zero after five ones
			ones_base   = in_frame_q ? ones_q : 3'd0;
			ones_inc    = item.in_bit ? ones_base + 3'd1 : 3'd0;
			plan.open   = !in_frame_q;
			plan.stuff  = (ones_inc >= 3'(RUN_LIMIT));
			plan.close  = item.frame_last;
			plan.data   = item.in_bit;
			plan.count  = CNT_W'(1) + CNT_W'(plan.stuff)
			            + (plan.open  ? CNT_W'(FLAG_BITS) : '0)
			            + (plan.close ? CNT_W'(FLAG_BITS) : '0);
			plan_valid  = 1'b1;
			ones_nxt    = plan.stuff ? 3'd0 : ones_inc;
		end else begin
			// deframer: drop header, delay line holds back the closing flag
			if (bits_seen_q < 5'(FLAG_BITS)) begin
				bits_seen_nxt = bits_seen_q + 5'd1;
			end else if (bits_seen_q < 5'(2 * FLAG_BITS)) begin
				delay_nxt     = {delay_q[6:0], item.in_bit};
				bits_seen_nxt = bits_seen_q + 5'd1;
			end else begin
				popped    = delay_q[7];
				delay_nxt = {delay_q[6:0], item.in_bit};
				if (ones_q >= 3'(RUN_LIMIT)) begin
					ones_nxt = 3'd0;
				end else begin
					ones_nxt = popped ? ones_q + 3'd1 : 3'd0;
					have     = 1'b1;
				end
			end
			plan.direct = 1'b1;
			plan.data   = have && popped;
			plan.has    = have;
			plan.fend   = item.frame_last;
			plan.count  = CNT_W'(1);
			plan_valid  = have || item.frame_last;
		end
		// end of frame clears the framing state
		if (item.frame_last) begin
			ones_nxt      = 3'd0;
			in_frame_nxt  = 1'b0;
			bits_seen_nxt = '0;
			delay_nxt     = '0;
		end
		ones_nxt_en = 1'b1;
	end

	// direction register and framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q       <= DIR_FRAME;
			ones_q      <= '0;
			in_frame_q  <= 1'b0;
			bits_seen_q <= '0;
			delay_q     <= '0;
		end else if (cfg_we) begin
			dir_q       <= cfg_wdata;
			ones_q      <= '0;
			in_frame_q  <= 1'b0;
			bits_seen_q <= '0;
			delay_q     <= '0;
		end else if (accept && ones_nxt_en) begin
			ones_q      <= ones_nxt;
			in_frame_q  <= in_frame_nxt;
			bits_seen_q <= bits_seen_nxt;
			delay_q     <= delay_nxt;
		end
	end

	// result sequencing
	hbsf_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept && plan_valid),
		.plan         (plan),
		.take_ok      (take_ok),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// checks
	a_frame_run_short: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q == DIR_FRAME |-> ones_q < 3'(RUN_LIMIT))
		else $error("framer ones run not cleared after stuffing");

	a_deframe_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ones_q <= 3'(RUN_LIMIT))
		else $error("ones run beyond limit");

	a_bits_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		bits_seen_q <= 5'(2 * FLAG_BITS))
		else $error("deframer bit count past saturation");

	a_frame_no_delay: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q == DIR_FRAME |-> bits_seen_q == '0 && delay_q == '0)
		else $error("deframer state active while framing");

endmodule
`default_nettype wire

// File: tb/tb_hdlc_bit_stuff_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdlc_bit_stuff_framer
// Self-checking bench for the HDLC framer / deframer. A directed table covers
// flags, zero insertion, frame ends, short frames and direction changes. It is
// followed by random framing and deframing phases. The deframing phases are
// mostly well-formed framed streams, with some broken stuffing and some noise.
// Every accepted request runs through a line model in the bench, and each
// result is checked field by field against the oldest bit still due.
// ----------------------------------------------------------------------------
module tb_hdlc_bit_stuff_framer;
	import hbsf_pkg::*;

	localparam int RAND_ITEMS  = 335;
	localparam int CALM_ITEMS  = 60;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 6;
	localparam int DRAIN       = 10;
	localparam int CYCLE_LIMIT = 600000;
	localparam int NUM_STEPS   = 19;

	// results that can be read off at a glance
	localparam result_t R_DATA_ONE = '{out_bit: 1'b1, has_bit: 1'b1, frame_end: 1'b0};
	localparam result_t R_STUFF    = '{out_bit: 1'b0, has_bit: 1'b1, frame_end: 1'b0};
	localparam result_t R_CLOSE    = '{out_bit: 1'b0, has_bit: 1'b1, frame_end: 1'b1};
	localparam result_t R_END_MARK = '{out_bit: 1'b0, has_bit: 1'b0, frame_end: 1'b1};
	localparam result_t R_NONE     = '{out_bit: 1'b0, has_bit: 1'b0, frame_end: 1'b0};

	// one directed request; pin is the final result of the request when pinned
	typedef struct packed {
		logic    dir;
		logic    in_bit;
		logic    frame_last;
		logic    pinned;
		result_t pin;
	} step_t;

	localparam step_t STEPS [NUM_STEPS] = '{
		// opening flag after reset, then a run of five ones with a stuffed zero
		'{DIR_FRAME,   1'b1, 1'b0, 1'b1, R_DATA_ONE},
		'{DIR_FRAME,   1'b1, 1'b0, 1'b0, R_NONE},
		'{DIR_FRAME,   1'b1, 1'b0, 1'b0, R_NONE},
		'{DIR_FRAME,   1'b1, 1'b0, 1'b0, R_NONE},
		'{DIR_FRAME,   1'b1, 1'b0, 1'b1, R_STUFF},
		'{DIR_FRAME,   1'b1, 1'b1, 1'b1, R_CLOSE},
		// one-bit frame
		'{DIR_FRAME,   1'b0, 1'b1, 1'b1, R_CLOSE},
		// stuffed zero on the last bit of a frame
		'{DIR_FRAME,   1'b1, 1'b0, 1'b0, R_NONE},
		'{DIR_FRAME,   1'b1, 1'b0, 1'b0, R_NONE},
		'{DIR_FRAME,   1'b1, 1'b0, 1'b0, R_NONE},
		'{DIR_FRAME,   1'b1, 1'b0, 1'b0, R_NONE},
		'{DIR_FRAME,   1'b1, 1'b1, 1'b1, R_CLOSE},
		// short deframed frames give only the end mark
		'{DIR_DEFRAME, 1'b0, 1'b0, 1'b0, R_NONE},
		'{DIR_DEFRAME, 1'b1, 1'b0, 1'b0, R_NONE},
		'{DIR_DEFRAME, 1'b1, 1'b1, 1'b1, R_END_MARK},
		'{DIR_DEFRAME, 1'b1, 1'b1, 1'b1, R_END_MARK},
		// open a frame, abandon it by a direction write, then start afresh
		'{DIR_FRAME,   1'b1, 1'b0, 1'b1, R_DATA_ONE},
		'{DIR_DEFRAME, 1'b0, 1'b1, 1'b1, R_END_MARK},
		'{DIR_FRAME,   1'b0, 1'b1, 1'b1, R_CLOSE}
	};

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	logic    cfg_we       = 1'b0;
	logic    cfg_wdata    = 1'b0;

	// line model state
	logic       m_dir;
	logic [2:0] m_run;
	logic       m_open;
	logic [4:0] m_seen;
	logic [7:0] m_delay;

	result_t line_due [$];
	logic    pending [$];

	bit calm     = 1'b0;
	bit gappy    = 1'b0;
	bit hold_req = 1'b0;

	int errors          = 0;
	int checked         = 0;
	int requests        = 0;
	int random_sent     = 0;
	int dir_writes      = 0;
	int frames_framed   = 0;
	int frames_deframed = 0;
	int held_stalls     = 0;

	hdlc_bit_stuff_framer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #1 clk = ~clk;

	// line model: clear all framing / deframing state
	function automatic void line_clear();
		m_run   = '0;
		m_open  = 1'b0;
		m_seen  = '0;
		m_delay = '0;
	endfunction

	function automatic void due_flag(input logic closing);
		int k;
		for (k = 0; k < FLAG_BITS; k++)
			line_due.push_back('{out_bit: FLAG_PATTERN[FLAG_BITS-1-k], has_bit: 1'b1,
				frame_end: closing && (k == FLAG_BITS - 1)});
	endfunction

	// line model: results due for one accepted request
	function automatic void hdlc_step(input logic b, input logic last);
		logic have;
		logic data;
		logic popped;
		if (m_dir == DIR_FRAME) begin
			if (!m_open) begin
				due_flag(1'b0);
				m_open = 1'b1;
				m_run  = '0;
			end
			m_run = b ? m_run + 3'd1 : 3'd0;
			line_due.push_back('{out_bit: b, has_bit: 1'b1, frame_end: 1'b0});
			if (m_run >= 3'(RUN_LIMIT)) begin
				line_due.push_back(R_STUFF);
				m_run = '0;
			end
			if (last) begin
				due_flag(1'b1);
				line_clear();
			end
		end else begin
			have   = 1'b0;
			data   = 1'b0;
			m_open = 1'b1;
			if (m_seen < 5'(FLAG_BITS)) begin
				m_seen = m_seen + 5'd1;
			end else if (m_seen < 5'(2 * FLAG_BITS)) begin
				m_delay = {m_delay[6:0], b};
				m_seen  = m_seen + 5'd1;
			end else begin
				popped  = m_delay[7];
				m_delay = {m_delay[6:0], b};
				if (m_run >= 3'(RUN_LIMIT)) begin
					// bit after five ones is dropped, whatever it is
					m_run = '0;
				end else begin
					m_run = popped ? m_run + 3'd1 : 3'd0;
					have  = 1'b1;
					data  = popped;
				end
			end
			if (last) begin
				line_due.push_back('{out_bit: have & data, has_bit: have, frame_end: 1'b1});
				line_clear();
			end else if (have) begin
				line_due.push_back('{out_bit: data, has_bit: 1'b1, frame_end: 1'b0});
			end
		end
	endfunction

	function automatic int pick_gap();
		if (calm || !gappy || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 17);
	endfunction

	// offer one request and wait for it to be taken
	task automatic send_bit(input logic b, input logic last, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item       <= '{in_bit: b, frame_last: last};
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		hdlc_step(b, last);
		requests++;
	endtask

	task automatic send_pending(input logic mark_end);
		int k;
		for (k = 0; k < pending.size(); k++)
			send_bit(pending[k], mark_end && (k == pending.size() - 1), pick_gap());
		random_sent += pending.size();
		pending.delete();
	endtask

	// direction write once the block has drained
	task automatic write_direction(input logic v);
		@(negedge clk);
		item_valid <= 1'b0;
		while (line_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		m_dir = v;
		line_clear();
		dir_writes++;
	endtask

	// framed stream: flag, stuffed payload, flag
	task automatic build_line_frame(input logic broken);
		int n;
		int k;
		int run;
		logic b;
		for (k = 0; k < FLAG_BITS; k++)
			pending.push_back(FLAG_PATTERN[FLAG_BITS-1-k]);
		n   = $urandom_range(0, 20);
		run = 0;
		for (k = 0; k < n; k++) begin
			b = ($urandom_range(0, 3) != 0);
			pending.push_back(b);
			run = b ? run + 1 : 0;
			if (run == RUN_LIMIT) begin
				pending.push_back(broken ? 1'($urandom_range(0, 1)) : 1'b0);
				run = 0;
			end
		end
		for (k = 0; k < FLAG_BITS; k++)
			pending.push_back(FLAG_PATTERN[FLAG_BITS-1-k]);
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && hold_req && item_valid && !item_ready)
			held_stalls++;
		if (arst_n && result_valid && result_ready) begin
			if (line_due.size() == 0) begin
				errors++;
				$display("%0t: nothing due, got out_bit=%b has_bit=%b frame_end=%b",
					$time, result.out_bit, result.has_bit, result.frame_end);
			end else begin
				want = line_due.pop_front();
				if (result.out_bit !== want.out_bit || result.has_bit !== want.has_bit ||
						result.frame_end !== want.frame_end) begin
					errors++;
					$display("%0t: result %0d expected %b/%b/%b got %b/%b/%b %s",
						$time, checked, want.out_bit, want.has_bit, want.frame_end,
						result.out_bit, result.has_bit, result.frame_end,
						"(out_bit/has_bit/frame_end)");
				end
			end
			checked++;
		end
	end

	// result side: random stalls, one long hold, none near the end
	initial begin : drive_result_ready
		int n;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ready <= 1'b0;
				for (n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(0, 16)) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	// run limit
	initial begin : watchdog
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("hdlc_bit_stuff_framer: mismatch");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int i;
		int f;
		int k;
		int n;
		int kind;
		int phase;
		int nframes;
		logic next_dir;
		m_dir = DIR_FRAME;
		line_clear();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (i = 0; i < NUM_STEPS; i++) begin
			if (STEPS[i].dir != m_dir)
				write_direction(STEPS[i].dir);
			send_bit(STEPS[i].in_bit, STEPS[i].frame_last, 0);
			if (STEPS[i].pinned) begin
				void'(line_due.pop_back());
				line_due.push_back(STEPS[i].pin);
			end
		end

		// random phases, each under a fresh direction write
		phase = 0;
		while (random_sent < RAND_ITEMS) begin
			if (phase == 0)
				next_dir = DIR_FRAME;
			else if (phase == 1)
				next_dir = DIR_DEFRAME;
			else
				next_dir = 1'($urandom_range(0, 1));
			write_direction(next_dir);
			// long hold on the result side while requests keep coming
			if (phase == 0)
				hold_req = 1'b1;
			nframes = $urandom_range(3, 6);
			for (f = 0; f < nframes && random_sent < RAND_ITEMS; f++) begin
				calm  = (random_sent >= RAND_ITEMS - CALM_ITEMS);
				gappy = ($urandom_range(0, 2) != 0);
				if (next_dir == DIR_FRAME) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
						: $urandom_range(1, 12);
					for (k = 0; k < n; k++)
						pending.push_back($urandom_range(0, 3) != 0);
					send_pending(1'b1);
					frames_framed++;
				end else begin
					kind = $urandom_range(0, 9);
					if (kind <= 7) begin
						// mostly clean streams, the odd one with a bad stuffed bit
						build_line_frame(kind == 7);
						send_pending(1'b1);
					end else begin
						n = $urandom_range(1, 30);
						for (k = 0; k < n; k++)
							pending.push_back(1'($urandom_range(0, 1)));
						send_pending(1'($urandom_range(0, 1)));
					end
					frames_deframed++;
				end
			end
			phase++;
		end

		// drain
		@(negedge clk);
		item_valid <= 1'b0;
		while (line_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("run: %0d requests (%0d from the table), %0d results checked",
			requests, NUM_STEPS, checked);
		$display("run: %0d direction writes, %0d framed and %0d deframed frames, %0d %s",
			dir_writes, frames_framed, frames_deframed, held_stalls,
			"input stall cycles under the long hold");
		if (errors == 0) begin
			$display("hdlc_bit_stuff_framer: match");
		end else begin
			$display("hdlc_bit_stuff_framer: mismatch");
		end
		$finish;
	end

endmodule
